FILE: hw/rtl/pop3_capa_response_parser_defines.svh
// Assertion macros shared by the POP3 CAPA reply parser.
// Depends on nothing; taken in by the top level with `include.
`ifndef POP3_CAPA_RESPONSE_PARSER_DEFINES_SVH
`define POP3_CAPA_RESPONSE_PARSER_DEFINES_SVH

// Implication in the same cycle, disabled while reset is held.
`define PCRP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pcrp assertion failed");

// Implication into the following cycle, disabled while reset is held.
`define PCRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pcrp assertion failed");

`endif

FILE: hw/rtl/pcrp_pkg.sv
// Package of the POP3 CAPA reply parser: phase codes, character constants,
// the parser state type and the lookups into the matched strings. No dependencies.
package pcrp_pkg;

    localparam logic [2:0] PH_INDICATOR = 3'd0;
    localparam logic [2:0] PH_SCAN      = 3'd1;
    localparam logic [2:0] PH_PIPE      = 3'd2;
    localparam logic [2:0] PH_LINEEND   = 3'd3;
    localparam logic [2:0] PH_DONE      = 3'd4;
    localparam logic [2:0] PH_ERROR     = 3'd5;

    localparam logic [3:0] OK_LEN   = 4'd3;
    localparam logic [3:0] PIPE_LEN = 4'd12;
    localparam logic [3:0] END_LEN  = 4'd5;

    // Position in the line-end string at which a '.' is expected.
    localparam logic [3:0] END_DOT_POS = 4'd2;

    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_P  = 8'h50;

    typedef struct packed {
        logic [2:0] phase;
        logic [3:0] pos;
        logic       seen;
    } t_pcrp_state;

    // Character of "+OK" at a position; positions past the end are never compared.
    function automatic logic [7:0] ok_char(input logic [3:0] p);
        logic [7:0] c;
        unique case (p)
            4'd0:    c = 8'h2b;
            4'd1:    c = 8'h4f;
            4'd2:    c = 8'h4b;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Character of "PIPELINING\r\n" at a position.
    function automatic logic [7:0] pipe_char(input logic [3:0] p);
        logic [7:0] c;
        unique case (p)
            4'd0:    c = CH_P;
            4'd1:    c = 8'h49;
            4'd2:    c = CH_P;
            4'd3:    c = 8'h45;
            4'd4:    c = 8'h4c;
            4'd5:    c = 8'h49;
            4'd6:    c = 8'h4e;
            4'd7:    c = 8'h49;
            4'd8:    c = 8'h4e;
            4'd9:    c = 8'h47;
            4'd10:   c = CH_CR;
            4'd11:   c = CH_LF;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Character of "\r\n.\r\n" at a position.
    function automatic logic [7:0] end_char(input logic [3:0] p);
        logic [7:0] c;
        unique case (p)
            4'd0:    c = CH_CR;
            4'd1:    c = CH_LF;
            4'd2:    c = 8'h2e;
            4'd3:    c = CH_CR;
            4'd4:    c = CH_LF;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/pcrp_step.sv
// Next-state logic of the POP3 CAPA reply parser for one byte.
// Depends on pcrp_pkg.
module pcrp_step (
    input  logic [7:0]           i_byte,
    input  pcrp_pkg::t_pcrp_state i_state,
    output pcrp_pkg::t_pcrp_state o_state
);

    always_comb begin
        o_state = i_state;
        unique case (i_state.phase)
            pcrp_pkg::PH_INDICATOR: begin
                if (i_state.pos >= pcrp_pkg::OK_LEN
                    || i_byte != pcrp_pkg::ok_char(i_state.pos)) begin
                    o_state.phase = pcrp_pkg::PH_ERROR;
                end else if (i_state.pos == pcrp_pkg::OK_LEN - 4'd1) begin
                    o_state.phase = pcrp_pkg::PH_SCAN;
                end else begin
                    o_state.pos = i_state.pos + 4'd1;
                end
            end
            pcrp_pkg::PH_SCAN: begin
                if (i_byte == pcrp_pkg::CH_CR) begin
                    o_state.phase = pcrp_pkg::PH_LINEEND;
                    o_state.pos   = 4'd1;
                end else if (i_byte == pcrp_pkg::CH_P) begin
                    o_state.phase = pcrp_pkg::PH_PIPE;
                    o_state.pos   = 4'd1;
                end
            end
            pcrp_pkg::PH_PIPE: begin
                if (i_state.pos >= pcrp_pkg::PIPE_LEN) begin
                    o_state.phase = pcrp_pkg::PH_ERROR;
                end else if (i_byte != pcrp_pkg::pipe_char(i_state.pos)) begin
                    o_state.phase = pcrp_pkg::PH_SCAN;
                end else if (i_state.pos == pcrp_pkg::PIPE_LEN - 4'd1) begin
                    // A whole capability line matched: continue where '.' may follow.
                    o_state.phase = pcrp_pkg::PH_LINEEND;
                    o_state.seen  = 1'b1;
                    o_state.pos   = pcrp_pkg::END_DOT_POS;
                end else begin
                    o_state.pos = i_state.pos + 4'd1;
                end
            end
            pcrp_pkg::PH_LINEEND: begin
                if (i_state.pos >= pcrp_pkg::END_LEN) begin
                    o_state.phase = pcrp_pkg::PH_ERROR;
                end else if (i_byte != pcrp_pkg::end_char(i_state.pos)
                             && i_state.pos == pcrp_pkg::END_DOT_POS) begin
                    if (i_byte == pcrp_pkg::CH_P) begin
                        o_state.phase = pcrp_pkg::PH_PIPE;
                        o_state.pos   = 4'd1;
                    end else begin
                        o_state.phase = pcrp_pkg::PH_SCAN;
                    end
                end else if (i_byte != pcrp_pkg::end_char(i_state.pos)) begin
                    o_state.phase = pcrp_pkg::PH_ERROR;
                end else if (i_state.pos == pcrp_pkg::END_LEN - 4'd1) begin
                    o_state.phase = pcrp_pkg::PH_DONE;
                end else begin
                    o_state.pos = i_state.pos + 4'd1;
                end
            end
            pcrp_pkg::PH_DONE, pcrp_pkg::PH_ERROR: begin
                o_state = i_state;
            end
            default: begin
                o_state.phase = pcrp_pkg::PH_ERROR;
            end
        endcase
    end

endmodule

FILE: hw/rtl/pop3_capa_response_parser.sv
// Top level of the POP3 CAPA reply parser: input register, parser state and result register.
// Depends on pcrp_pkg, pcrp_step and pop3_capa_response_parser_defines.svh.
//
// Usage: the bytes of a server's CAPA reply enter one word at a time on the input
// channel (i_in_valid, o_in_ready, i_byte_in). For every word accepted the block
// returns exactly one result word on the output channel (o_out_valid, i_out_ready):
// the parse phase after that byte, the finished and errored flags, and the sticky
// pipelining-available flag.
// From acceptance, a byte is held in the input register and then passes through the
// state update into the result register, which offers it. Throughput is one byte per
// cycle while the receiver does not stall; the limit is the single state update per cycle,
// which is a short compare-and-transition path fed from the input register.
// When the receiver stalls, the result register holds its word, the input register
// fills, and o_in_ready falls only once both are occupied; it rises again in the
// same cycle as the receiver takes the result.
// A synchronous active-low reset empties both registers and returns the parser to
// the indicator phase with the pipelining flag cleared. Done and error persist
// until the next reset; later bytes are still accepted and answered.
`include "pop3_capa_response_parser_defines.svh"

module pop3_capa_response_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_byte_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_parse_state,
    output logic       o_finished,
    output logic       o_errored,
    output logic       o_pipelining_available
);

    // Input register: one byte waiting for the state update.
    logic                  r_in_valid;
    logic [7:0]            r_byte;

    // Parser state, advanced once for each byte that leaves the input register.
    pcrp_pkg::t_pcrp_state r_state;
    pcrp_pkg::t_pcrp_state n_state;

    // Result register.
    logic                  r_out_valid;
    logic [2:0]            r_out_phase;
    logic                  r_out_seen;

    logic                  w_advance;

    // A byte moves on when the result register is empty or is being emptied.
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    pcrp_step u_step (
        .i_byte  (r_byte),
        .i_state (r_state),
        .o_state (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_byte <= i_byte_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase <= pcrp_pkg::PH_INDICATOR;
            r_state.pos   <= 4'd0;
            r_state.seen  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else if (w_advance) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_phase <= n_state.phase;
            r_out_seen  <= n_state.seen;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_parse_state          = r_out_phase;
    assign o_finished             = (r_out_phase == pcrp_pkg::PH_DONE)
                                    || (r_out_phase == pcrp_pkg::PH_ERROR);
    assign o_errored              = (r_out_phase == pcrp_pkg::PH_ERROR);
    assign o_pipelining_available = r_out_seen;

    // Done and error are absorbing, and the pipelining flag never clears.
    `PCRP_ASSERT_NEXT(a_done_holds, i_clk, i_rst_n, r_state.phase == pcrp_pkg::PH_DONE, r_state.phase == pcrp_pkg::PH_DONE)
    `PCRP_ASSERT_NEXT(a_error_holds, i_clk, i_rst_n, r_state.phase == pcrp_pkg::PH_ERROR, r_state.phase == pcrp_pkg::PH_ERROR)
    `PCRP_ASSERT_NEXT(a_seen_sticky, i_clk, i_rst_n, r_state.seen, r_state.seen)
    // A result on offer always reflects the current parser state.
    `PCRP_ASSERT_IMPL(a_result_matches_state, i_clk, i_rst_n, r_out_valid, r_out_phase == r_state.phase && r_out_seen == r_state.seen)

endmodule

FILE: sim/capa_parse_checker.sv
// Checker for the POP3 CAPA reply parser: watches both word channels, predicts each result
// from the bytes accepted so far and compares it with what the block returns.
// Depends on pcrp_pkg for the phase codes, string lengths and character constants.
module capa_parse_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_byte_in,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [2:0] i_parse_state,
    input  logic       i_finished,
    input  logic       i_errored,
    input  logic       i_pipelining_available,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0] parse_state;
        logic       finished;
        logic       errored;
        logic       pipelining;
    } t_capa_result;

    localparam logic [7:0]  CH_DOT     = 8'h2e;
    localparam logic [95:0] OK_TEXT    = {72'd0, "+OK"};
    localparam logic [95:0] PIPE_TEXT  = {"PIPELINING", pcrp_pkg::CH_CR, pcrp_pkg::CH_LF};
    localparam logic [95:0] CLOSE_TEXT = {56'd0, pcrp_pkg::CH_CR, pcrp_pkg::CH_LF, CH_DOT,
                                          pcrp_pkg::CH_CR, pcrp_pkg::CH_LF};

    logic [2:0]   parser_phase;
    logic [3:0]   match_pos;
    logic         pipelining_seen;
    t_capa_result expected_results[$];
    int           fails    = 0;
    int           reported = 0;

    // Character at a position of a string held right-aligned, first character highest.
    function automatic logic [7:0] text_char(input logic [95:0] s, input logic [3:0] len,
                                             input logic [3:0] p);
        return s[8 * (int'(len) - 1 - int'(p)) +: 8];
    endfunction

    // Applies one byte to the predicted parser state.
    function automatic void parse_byte(input logic [7:0] b);
        case (parser_phase)
            pcrp_pkg::PH_INDICATOR: begin
                if (match_pos >= pcrp_pkg::OK_LEN
                    || b != text_char(OK_TEXT, pcrp_pkg::OK_LEN, match_pos))
                    parser_phase = pcrp_pkg::PH_ERROR;
                else if (match_pos == pcrp_pkg::OK_LEN - 4'd1)
                    parser_phase = pcrp_pkg::PH_SCAN;
                else
                    match_pos = match_pos + 4'd1;
            end
            pcrp_pkg::PH_SCAN: begin
                if (b == pcrp_pkg::CH_CR) begin
                    parser_phase = pcrp_pkg::PH_LINEEND;
                    match_pos    = 4'd1;
                end else if (b == pcrp_pkg::CH_P) begin
                    parser_phase = pcrp_pkg::PH_PIPE;
                    match_pos    = 4'd1;
                end
            end
            pcrp_pkg::PH_PIPE: begin
                if (match_pos >= pcrp_pkg::PIPE_LEN) begin
                    parser_phase = pcrp_pkg::PH_ERROR;
                end else if (b != text_char(PIPE_TEXT, pcrp_pkg::PIPE_LEN, match_pos)) begin
                    parser_phase = pcrp_pkg::PH_SCAN;
                end else if (match_pos == pcrp_pkg::PIPE_LEN - 4'd1) begin
                    parser_phase    = pcrp_pkg::PH_LINEEND;
                    pipelining_seen = 1'b1;
                    match_pos       = pcrp_pkg::END_DOT_POS;
                end else begin
                    match_pos = match_pos + 4'd1;
                end
            end
            pcrp_pkg::PH_LINEEND: begin
                if (match_pos >= pcrp_pkg::END_LEN) begin
                    parser_phase = pcrp_pkg::PH_ERROR;
                end else if (b != text_char(CLOSE_TEXT, pcrp_pkg::END_LEN, match_pos)) begin
                    // Only the start of a line tolerates a different byte.
                    if (match_pos != pcrp_pkg::END_DOT_POS) begin
                        parser_phase = pcrp_pkg::PH_ERROR;
                    end else if (b == pcrp_pkg::CH_P) begin
                        parser_phase = pcrp_pkg::PH_PIPE;
                        match_pos    = 4'd1;
                    end else begin
                        parser_phase = pcrp_pkg::PH_SCAN;
                    end
                end else if (match_pos == pcrp_pkg::END_LEN - 4'd1) begin
                    parser_phase = pcrp_pkg::PH_DONE;
                end else begin
                    match_pos = match_pos + 4'd1;
                end
            end
            pcrp_pkg::PH_DONE, pcrp_pkg::PH_ERROR: ;
            default: parser_phase = pcrp_pkg::PH_ERROR;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_capa_result want;
        t_capa_result got;
        if (!i_rst_n) begin
            parser_phase    = pcrp_pkg::PH_INDICATOR;
            match_pos       = 4'd0;
            pipelining_seen = 1'b0;
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                parse_byte(i_byte_in);
                want.parse_state = parser_phase;
                want.finished    = (parser_phase == pcrp_pkg::PH_DONE)
                                   || (parser_phase == pcrp_pkg::PH_ERROR);
                want.errored     = (parser_phase == pcrp_pkg::PH_ERROR);
                want.pipelining  = pipelining_seen;
                expected_results.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                got = {i_parse_state, i_finished, i_errored, i_pipelining_available};
                if (expected_results.size() == 0) begin
                    fails++;
                    if (reported < 10) begin
                        reported++;
                        $display("%0t: unexpected result word state=%0d fin=%b err=%b pipe=%b",
                                 $realtime, got.parse_state, got.finished, got.errored,
                                 got.pipelining);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got.parse_state !== want.parse_state || got.finished !== want.finished
                        || got.errored !== want.errored || got.pipelining !== want.pipelining)
                    begin
                        fails++;
                        if (reported < 10) begin
                            reported++;
                            $display("%0t: result mismatch expected state=%0d fin=%b err=%b pipe=%b",
                                     $realtime, want.parse_state, want.finished, want.errored,
                                     want.pipelining);
                            $display("%0t:                 actual   state=%0d fin=%b err=%b pipe=%b",
                                     $realtime, got.parse_state, got.finished, got.errored,
                                     got.pipelining);
                        end
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_results.size();
    end

endmodule

FILE: sim/tb.sv
// Testbench top for the POP3 CAPA reply parser: clock, reset, byte stimulus and verdict.
// Depends on pcrp_pkg, the parser RTL and capa_parse_checker, which does all the checking.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Shapes of the lines that make up the body of a reply.
    typedef enum {LINE_TEXT, LINE_PIPELINING, LINE_NEAR_MISS} t_capa_line;

    // How the reply is brought to an end: a clean terminator, or one of the
    // malformed endings that must drive the parser into error.
    typedef enum {REPLY_CLEAN, REPLY_BARE_CR, REPLY_DOT_JUNK, REPLY_DOT_CR_JUNK} t_reply_end;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte   = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] parse_state;
    logic       finished;
    logic       errored;
    logic       pipelining_available;

    int fail_count;
    int pending;
    int words_sent = 0;
    bit tx_steady  = 1'b0;
    bit rx_steady  = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    pop3_capa_response_parser dut (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .i_in_valid             (in_valid),
        .o_in_ready             (in_ready),
        .i_byte_in              (in_byte),
        .o_out_valid            (out_valid),
        .i_out_ready            (out_ready),
        .o_parse_state          (parse_state),
        .o_finished             (finished),
        .o_errored              (errored),
        .o_pipelining_available (pipelining_available)
    );

    capa_parse_checker checker_i (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .i_in_valid             (in_valid),
        .i_in_ready             (in_ready),
        .i_byte_in              (in_byte),
        .i_out_valid            (out_valid),
        .i_out_ready            (out_ready),
        .i_parse_state          (parse_state),
        .i_finished             (finished),
        .i_errored              (errored),
        .i_pipelining_available (pipelining_available),
        .o_fail_count           (fail_count),
        .o_pending              (pending)
    );

    // Offers one word on the input channel and returns at the edge where it is
    // taken. Valid is only lowered when a gap is wanted, so that back-to-back
    // words keep valid high without a second assignment in the same step.
    task automatic send_word(input logic [7:0] b);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) send_word(s[i]);
    endtask

    task automatic send_crlf();
        send_word(pcrp_pkg::CH_CR);
        send_word(pcrp_pkg::CH_LF);
    endtask

    // A byte of free line text. Carriage returns are kept out, since a lone one
    // would end the reply in error; capital P is made more likely so that
    // pipelining matches start and fail often. A line must not open with a full
    // stop, which would be taken as the start of the terminator.
    function automatic logic [7:0] text_byte(input bit first);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0 || b == pcrp_pkg::CH_CR)
            b = pcrp_pkg::CH_P;
        if (first && b == ".")
            b = "a";
        return b;
    endfunction

    // Character of the pipelining capability line at a position.
    function automatic logic [7:0] pipe_at(input int p);
        string name;
        name = "PIPELINING";
        if (p < name.len())
            return name[p];
        return (p == name.len()) ? pcrp_pkg::CH_CR : pcrp_pkg::CH_LF;
    endfunction

    // Sends one line of the reply body. Near misses follow the capability name
    // for a while and then break off with a wrong byte, which the parser must drop.
    task automatic send_line();
        int         roll;
        int         len;
        int         k;
        logic [7:0] b;
        t_capa_line kind;
        roll      = $urandom_range(0, 7);
        kind      = (roll < 4) ? LINE_TEXT : (roll < 6) ? LINE_PIPELINING : LINE_NEAR_MISS;
        tx_steady = ($urandom_range(0, 3) == 0);
        case (kind)
            LINE_TEXT: begin
                len = $urandom_range(0, 12);
                for (int i = 0; i < len; i++) send_word(text_byte(i == 0));
                send_crlf();
            end
            LINE_PIPELINING: begin
                send_string("PIPELINING");
                send_crlf();
            end
            LINE_NEAR_MISS: begin
                k = $urandom_range(1, 11);
                for (int i = 0; i < k; i++) send_word(pipe_at(i));
                b = 8'($urandom_range(0, 255));
                if (b == pipe_at(k))
                    b = b ^ 8'h01;
                send_word(b);
                len = $urandom_range(0, 6);
                for (int i = 0; i < len; i++) send_word(text_byte(1'b0));
                send_crlf();
            end
        endcase
    endtask

    // The receiving side stalls for a random number of cycles before each
    // result word, with stretches of no stalling at all.
    initial begin
        int stall;
        int taken;
        taken = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (taken % 40 == 0)
                rx_steady = ($urandom_range(0, 2) == 0);
            stall = rx_steady ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            taken++;
        end
    end

    initial begin
        int         guard;
        logic [7:0] b;
        t_reply_end ending;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening: the status indicator, a capability line that sets
        // the flag, a pipelining match begun at the start of a line and broken
        // at once, a carriage return dropped while matching, the extreme byte
        // values in a line of text, and a line that opens with an ordinary byte.
        send_string("+OK");
        send_crlf();
        send_string("PIPELINING");
        send_crlf();
        send_string("PX");
        send_string("P");
        send_word(pcrp_pkg::CH_CR);
        send_word(8'hff);
        send_word(8'h00);
        send_crlf();
        send_string("x");

        // Random body of well-formed lines with random content.
        while (words_sent < 1000) send_line();

        // The byte 'a' brings the parser back to scanning from wherever the
        // body left it, so that each ending is met in a known phase.
        tx_steady = 1'b0;
        send_string("a");
        ending = t_reply_end'($urandom_range(0, 3));
        case (ending)
            REPLY_CLEAN: begin
                send_crlf();
                send_string(".");
                send_crlf();
            end
            REPLY_BARE_CR: begin
                send_word(pcrp_pkg::CH_CR);
                b = 8'($urandom_range(0, 255));
                send_word((b == pcrp_pkg::CH_LF) ? 8'h5a : b);
            end
            REPLY_DOT_JUNK: begin
                send_crlf();
                send_string(".");
                b = 8'($urandom_range(0, 255));
                send_word((b == pcrp_pkg::CH_CR) ? 8'h5a : b);
            end
            REPLY_DOT_CR_JUNK: begin
                send_crlf();
                send_string(".");
                send_word(pcrp_pkg::CH_CR);
                b = 8'($urandom_range(0, 255));
                send_word((b == pcrp_pkg::CH_LF) ? 8'h5a : b);
            end
        endcase

        // Words after the end must be answered with the final state unchanged.
        for (int i = 0; i < 8; i++) send_word(8'($urandom_range(0, 255)));
        in_valid <= 1'b0;

        // Once the checker has counted the last word, let every outstanding result
        // drain before the verdict.
        @(posedge clk);
        guard = 0;
        while (pending != 0 && guard < 2000) begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: set far beyond the slowest correct run.
    initial begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
